FILE: hw/rtl/tcc_pkg.sv
package tcc_pkg;

  localparam int SCREEN_WIDTH  = 240;
  localparam int SCREEN_HEIGHT = 320;
  localparam int GLYPH_WIDTH   = 6;
  localparam int GLYPH_HEIGHT  = 8;
  localparam int BAND_COUNT    = 20;

  localparam int BAND_LOG    = 4;
  localparam int BAND_PIXELS = 1 << BAND_LOG;
  localparam int BAND_IDX_W  = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;

  localparam int COORD_W = 10;
  localparam int ALU_W   = COORD_W + 1;
  localparam int CELL_W  = 8;
  localparam int SCALE_W = 4;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd2;
  localparam logic [SCALE_W-1:0] SCALE_MAX   = 4'd8;
  localparam logic [COORD_W-1:0] ROW_MAX     = 10'd1023;

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_BACK  = 2'd1,
    MODE_SET   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_RETURN  = 8'd13;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;

  localparam logic KIND_GLYPH = 1'b0;
  localparam logic KIND_FILL  = 1'b1;

  typedef struct packed {
    logic             carry;
    logic [ALU_W-1:0] value;
  } alu_res_t;

  typedef struct packed {
    logic                  any;
    logic                  only_one;
    logic [BAND_IDX_W-1:0] idx;
  } band_stat_t;

  // cell edge in pixels for a raw scale register value
  function automatic logic [CELL_W-1:0] cell_size(input logic [SCALE_W-1:0] scale,
                                                  input int glyph);
    logic [SCALE_W-1:0] eff;
    eff = scale;
    if (scale == '0) eff = 4'd1;
    else if (scale > SCALE_MAX) eff = SCALE_MAX;
    return CELL_W'(eff * glyph);
  endfunction

endpackage

FILE: hw/rtl/text_console_cursor_controller.sv
// a printable character goes through wrap check, row wrap if needed and glyph state;
// newline steps the row; carriage return and set position finish on accept;
// backspace steps back then emits a fill; a clear emits one fill per dirty band
// throughput: one item at a time; every cursor step goes through the single shared adder
// a clear emits one band fill per cycle while the output register drains
// reset (rst, synchronous): cursor at origin, all bands clean, scale 2, no word pending
module text_console_cursor_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  char_code,
  input  logic [9:0]  pos_x,
  input  logic [9:0]  pos_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [9:0]  rect_x,
  output logic [9:0]  rect_y,
  output logic [9:0]  rect_width,
  output logic [9:0]  rect_height,
  output logic [7:0]  glyph_code,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP_CHK,
    ST_ROW_WRAP,
    ST_ROW_NL,
    ST_GLYPH,
    ST_BS_COL,
    ST_BS_ROW,
    ST_BS_EMIT,
    ST_CLEAR
  } state_t;

  state_t state;

  logic [tcc_pkg::CELL_W-1:0]  cell_w;
  logic [tcc_pkg::CELL_W-1:0]  cell_h;
  logic [tcc_pkg::COORD_W-1:0] cursor_col;
  logic [tcc_pkg::COORD_W-1:0] cursor_row;
  logic [7:0]                  code;

  logic [tcc_pkg::ALU_W-1:0] alu_a;
  logic [tcc_pkg::ALU_W-1:0] alu_b;
  logic                      alu_sub;
  tcc_pkg::alu_res_t         alu_res;
  tcc_pkg::band_stat_t       band_stat;

  logic in_take;
  logic out_free;
  logic out_load;
  logic band_mark;
  logic band_clr;
  logic glyph_vis;
  logic [tcc_pkg::COORD_W-1:0] add_sat;
  logic [tcc_pkg::COORD_W-1:0] sub_clamp;

  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  assign band_mark = in_take && (tcc_pkg::mode_t'(mode) == tcc_pkg::MODE_PUT);
  assign band_clr  = (state == ST_CLEAR) && band_stat.any && out_free;

  // a new word enters the output register this cycle
  assign out_load  = out_free && (((state == ST_GLYPH) && glyph_vis) ||
                                  (state == ST_BS_EMIT) || band_clr);

  assign add_sat   = alu_res.value[tcc_pkg::COORD_W] ? tcc_pkg::ROW_MAX
                                                     : alu_res.value[tcc_pkg::COORD_W-1:0];
  assign sub_clamp = alu_res.carry ? '0 : alu_res.value[tcc_pkg::COORD_W-1:0];

  assign glyph_vis = (32'(cursor_col) < tcc_pkg::SCREEN_WIDTH) &&
                     (32'(cursor_row) < tcc_pkg::SCREEN_HEIGHT) &&
                     (code >= tcc_pkg::CHAR_SPACE);

  // operand select for the shared adder
  always_comb begin
    alu_a   = tcc_pkg::ALU_W'(cursor_col);
    alu_b   = tcc_pkg::ALU_W'(cell_w);
    alu_sub = 1'b0;
    unique case (state)
      ST_ROW_WRAP, ST_ROW_NL: begin
        alu_a = tcc_pkg::ALU_W'(cursor_row);
        alu_b = tcc_pkg::ALU_W'(cell_h);
      end
      ST_BS_COL: begin
        alu_sub = 1'b1;
        if (cursor_col == '0) alu_a = tcc_pkg::ALU_W'(tcc_pkg::SCREEN_WIDTH);
      end
      ST_BS_ROW: begin
        alu_sub = 1'b1;
        alu_a   = tcc_pkg::ALU_W'(cursor_row);
        alu_b   = tcc_pkg::ALU_W'(cell_h);
      end
      default: begin
      end
    endcase
  end

  tcc_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  tcc_band_map u_band_map (
    .clk      (clk),
    .rst      (rst),
    .mark     (band_mark),
    .mark_row (cursor_row),
    .clr      (band_clr),
    .stat     (band_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cell_w     <= tcc_pkg::cell_size(tcc_pkg::SCALE_RESET, tcc_pkg::GLYPH_WIDTH);
      cell_h     <= tcc_pkg::cell_size(tcc_pkg::SCALE_RESET, tcc_pkg::GLYPH_HEIGHT);
      cursor_col <= '0;
      cursor_row <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cell_w <= tcc_pkg::cell_size(cfg_data, tcc_pkg::GLYPH_WIDTH);
        cell_h <= tcc_pkg::cell_size(cfg_data, tcc_pkg::GLYPH_HEIGHT);
      end
      if (out_valid && !out_stall && !out_load) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            code <= char_code;
            unique case (tcc_pkg::mode_t'(mode))
              tcc_pkg::MODE_PUT: begin
                if (char_code == tcc_pkg::CHAR_NEWLINE) begin
                  cursor_col <= '0;
                  state      <= ST_ROW_NL;
                end else if (char_code != tcc_pkg::CHAR_RETURN) begin
                  state <= ST_WRAP_CHK;
                end
              end
              tcc_pkg::MODE_BACK: begin
                if (cursor_col != '0 || cursor_row != '0) state <= ST_BS_COL;
              end
              tcc_pkg::MODE_SET: begin
                cursor_col <= pos_x;
                cursor_row <= pos_y;
              end
              tcc_pkg::MODE_CLEAR: state <= ST_CLEAR;
              default: begin
              end
            endcase
          end
        end
        ST_WRAP_CHK: begin
          if (32'(alu_res.value) > tcc_pkg::SCREEN_WIDTH) begin
            cursor_col <= '0;
            state      <= ST_ROW_WRAP;
          end else begin
            state <= ST_GLYPH;
          end
        end
        ST_ROW_WRAP: begin
          cursor_row <= add_sat;
          state      <= ST_GLYPH;
        end
        ST_ROW_NL: begin
          cursor_row <= add_sat;
          state      <= ST_IDLE;
        end
        ST_GLYPH: begin
          // a visible glyph waits for the output slot before the cursor moves
          if (!glyph_vis || out_free) begin
            cursor_col <= add_sat;
            state      <= ST_IDLE;
            if (glyph_vis) begin
              out_valid   <= 1'b1;
              kind        <= tcc_pkg::KIND_GLYPH;
              rect_x      <= cursor_col;
              rect_y      <= cursor_row;
              rect_width  <= '0;
              rect_height <= '0;
              glyph_code  <= code;
              last        <= 1'b1;
            end
          end
        end
        ST_BS_COL: begin
          cursor_col <= sub_clamp;
          state      <= (cursor_col == '0) ? ST_BS_ROW : ST_BS_EMIT;
        end
        ST_BS_ROW: begin
          cursor_row <= sub_clamp;
          state      <= ST_BS_EMIT;
        end
        ST_BS_EMIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            kind        <= tcc_pkg::KIND_FILL;
            rect_x      <= cursor_col;
            rect_y      <= cursor_row;
            rect_width  <= tcc_pkg::COORD_W'(cell_w);
            rect_height <= tcc_pkg::COORD_W'(cell_h);
            glyph_code  <= '0;
            last        <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        ST_CLEAR: begin
          if (!band_stat.any) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_valid   <= 1'b1;
            kind        <= tcc_pkg::KIND_FILL;
            rect_x      <= '0;
            rect_y      <= tcc_pkg::COORD_W'(band_stat.idx) << tcc_pkg::BAND_LOG;
            rect_width  <= tcc_pkg::COORD_W'(tcc_pkg::SCREEN_WIDTH);
            rect_height <= tcc_pkg::COORD_W'(tcc_pkg::BAND_PIXELS);
            glyph_code  <= '0;
            last        <= band_stat.only_one;
            if (band_stat.only_one) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_set_pos: assert property (@(posedge clk) disable iff (rst)
    (in_take && tcc_pkg::mode_t'(mode) == tcc_pkg::MODE_SET) |=>
      (cursor_col == $past(pos_x) && cursor_row == $past(pos_y)))
    else $error("set position not applied");

  a_glyph_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == tcc_pkg::KIND_GLYPH) |->
      (rect_width == '0 && rect_height == '0 && glyph_code >= tcc_pkg::CHAR_SPACE))
    else $error("glyph word with size or control code");

  a_fill_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == tcc_pkg::KIND_FILL) |-> (glyph_code == '0 && rect_width != '0))
    else $error("fill word malformed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(rect_x) && $stable(rect_y) && $stable(last)))
    else $error("pending word overwritten");

endmodule

FILE: hw/rtl/tcc_alu.sv
module tcc_alu (
  input  logic [tcc_pkg::ALU_W-1:0] a,
  input  logic [tcc_pkg::ALU_W-1:0] b,
  input  logic                      sub,
  output tcc_pkg::alu_res_t         res
);

  logic [tcc_pkg::ALU_W:0] sum;

  // carry is the overflow bit on add and the borrow on subtract
  always_comb begin
    if (sub) begin
      sum = {1'b0, a} - {1'b0, b};
    end else begin
      sum = {1'b0, a} + {1'b0, b};
    end
    res.carry = sum[tcc_pkg::ALU_W];
    res.value = sum[tcc_pkg::ALU_W-1:0];
  end

endmodule

FILE: hw/rtl/tcc_band_map.sv
module tcc_band_map (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          mark,
  input  logic [tcc_pkg::COORD_W-1:0]   mark_row,
  input  logic                          clr,
  output tcc_pkg::band_stat_t           stat
);

  logic [tcc_pkg::BAND_COUNT-1:0] dirty;
  logic [tcc_pkg::COORD_W-tcc_pkg::BAND_LOG-1:0] band;
  logic [tcc_pkg::BAND_IDX_W-1:0] low_idx;

  assign band = mark_row[tcc_pkg::COORD_W-1:tcc_pkg::BAND_LOG];

  // lowest dirty band
  always_comb begin
    low_idx = '0;
    for (int i = tcc_pkg::BAND_COUNT - 1; i >= 0; i--) begin
      if (dirty[tcc_pkg::BAND_IDX_W'(i)]) low_idx = tcc_pkg::BAND_IDX_W'(i);
    end
  end

  assign stat.any      = |dirty;
  assign stat.only_one = (dirty & (dirty - 1'b1)) == '0;
  assign stat.idx      = low_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      dirty <= '0;
    end else if (mark) begin
      if (32'(band) < tcc_pkg::BAND_COUNT) begin
        dirty[band[tcc_pkg::BAND_IDX_W-1:0]] <= 1'b1;
      end
    end else if (clr) begin
      dirty[low_idx] <= 1'b0;
    end
  end

endmodule
